/* hw/rtl/qte_pkg.sv */
// ----------------------------------------------------------------------------
// qte_pkg: shared types and constants for the quaternion to Euler block
// Widths of the product, CORDIC and root datapaths, trim settings and the
// arctangent table in degrees with 16 fraction bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qte_pkg;

  // trim averaging
  localparam int TRIM_SAMPLES = 100;
  localparam int TRIM_HALF    = TRIM_SAMPLES / 2;
  localparam int REM_W        = $clog2(TRIM_SAMPLES);
  localparam int TACC_W       = 24;
  localparam int TACC_CNT_W   = $clog2(TACC_W);

  // CORDIC
  localparam int CORDIC_STEPS = 16;
  localparam int TAB_LEN      = 24;
  localparam int CORDIC_ITERS = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;
  localparam int STEP_W       = $clog2(CORDIC_ITERS + 1);
  localparam int CW           = 38;   // vector width
  localparam int ZW           = 27;   // angle accumulator, Q16 degrees
  localparam int ANG_W        = ZW - 8;

  // products and root
  localparam int MUL_BITS     = 16;
  localparam int ACC_W        = 34;
  localparam int S_W          = 32;
  localparam int SQ_W         = 31;

  typedef struct packed {
    logic signed [ACC_W-1:0] yaw_num;   // xy + wz
    logic signed [ACC_W-1:0] yaw_den;   // yy + zz
    logic signed [ACC_W-1:0] roll_num;  // yz + wx
    logic signed [ACC_W-1:0] roll_den;  // xx + yy
    logic signed [ACC_W-1:0] pitch_sin; // wy - xz
  } prod_t;

  // atan(2^-i) in degrees, Q16
  function automatic logic [21:0] atan_deg(input logic [4:0] i);
    logic [21:0] v;
    case (i)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

/* hw/rtl/quaternion_to_euler_with_level_trim.sv */
// ----------------------------------------------------------------------------
// quaternion_to_euler_with_level_trim: attitude quaternion to ZYX angles
// Serial product sums, square root and three CORDIC units, plus level trim
// averaging on pitch and roll.
// ----------------------------------------------------------------------------
// Each item passes through bit-serial product sums, squaring of the pitch
// sine and the root of its complement, then the pitch CORDIC (yaw and roll
// CORDICs run under the root), and then the result is loaded.
// The sample that ends trim averaging adds a serial division that loads
// the new trims before the next item is taken. A finished result waits
// in the output register while the next item is accepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quaternion_to_euler_with_level_trim
  import qte_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  input  logic               start_calibration,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [16:0] yaw_angle,
  output logic signed [16:0] pitch_angle,
  output logic signed [17:0] roll_angle,
  output logic               calibrating,
  output logic               calibration_done
);

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_ROOT, S_ANGLE, S_OUT, S_DIV} state_t;

  localparam logic signed [CW-1:0] ONE_Q30 = CW'(1) <<< 30;
  localparam logic signed [19:0]   LIM_HALF = 20'sd46080;
  localparam logic signed [19:0]   LIM_FULL = 20'sd92160;

  state_t state;

  logic               accept, out_free, angle_start, pitch_start;
  logic               mul_fin, root_fin, yaw_fin, roll_fin, pitch_fin;
  prod_t              prod;
  logic signed [CW-1:0] yaw_x, yaw_y, roll_x, roll_y, sin2, sin_clamp;
  logic signed [CW-1:0] pitch_x, pitch_y;
  logic signed [S_W-1:0] sine;
  logic [SQ_W-1:0]    cosine;
  logic signed [ANG_W-1:0] yaw_raw, roll_raw, pitch_raw;

  logic signed [17:0]       roll_trim, pitch_trim;
  logic signed [TACC_W-1:0] roll_acc, pitch_acc, roll_sum, pitch_sum;
  logic [6:0]               sample_cnt, cnt_inc;
  logic                     active, final_hit;

  logic [TACC_W-1:0]     roll_q, pitch_q;
  logic [REM_W-1:0]      roll_rem, pitch_rem;
  logic [REM_W:0]        roll_r2, pitch_r2;
  logic                  roll_neg, pitch_neg, roll_qb, pitch_qb;
  logic [TACC_CNT_W-1:0] div_cnt;

  function automatic logic signed [19:0] sat20(input logic signed [19:0] v,
                                               input logic signed [19:0] lim);
    logic signed [19:0] r;
    if (v > lim) r = lim;
    else if (v < -lim) r = -lim;
    else r = v;
    return r;
  endfunction

  function automatic logic [TACC_W-1:0] mag_half(input logic signed [TACC_W-1:0] v);
    logic [TACC_W-1:0] m;
    m = v[TACC_W-1] ? TACC_W'(-v) : TACC_W'(v);
    return m + TACC_W'(TRIM_HALF);
  endfunction

  // handshake and unit starts
  assign in_ready    = (state == S_IDLE);
  assign accept      = in_valid & in_ready;
  assign out_free    = !out_valid || out_ready;
  assign angle_start = (state == S_MUL) && mul_fin;
  assign pitch_start = (state == S_ROOT) && root_fin;

  // CORDIC operands from the product sums
  assign yaw_y     = CW'(prod.yaw_num) <<< 1;
  assign yaw_x     = ONE_Q30 - (CW'(prod.yaw_den) <<< 1);
  assign roll_y    = CW'(prod.roll_num) <<< 1;
  assign roll_x    = ONE_Q30 - (CW'(prod.roll_den) <<< 1);
  assign sin2      = CW'(prod.pitch_sin) <<< 1;
  assign sin_clamp = (sin2 > ONE_Q30) ? ONE_Q30 : ((sin2 < -ONE_Q30) ? -ONE_Q30 : sin2);
  assign sine      = S_W'(sin_clamp);
  assign pitch_y   = CW'(sine);
  assign pitch_x   = CW'($signed({1'b0, cosine}));

  // trim averaging bookkeeping
  assign roll_sum  = roll_acc + TACC_W'(roll_raw);
  assign pitch_sum = pitch_acc + TACC_W'(pitch_raw);
  assign cnt_inc   = sample_cnt + 7'd1;
  assign final_hit = active && (cnt_inc >= 7'(TRIM_SAMPLES));

  // restoring division by the sample count
  assign roll_r2   = {roll_rem, roll_q[TACC_W-1]};
  assign pitch_r2  = {pitch_rem, pitch_q[TACC_W-1]};
  assign roll_qb   = roll_r2 >= (REM_W + 1)'(TRIM_SAMPLES);
  assign pitch_qb  = pitch_r2 >= (REM_W + 1)'(TRIM_SAMPLES);

  qte_mul u_mul (
    .clk(clk), .rst(rst), .start(accept),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .prod(prod), .finished(mul_fin)
  );

  qte_root u_root (
    .clk(clk), .rst(rst), .start(angle_start),
    .sine(sine), .cosine(cosine), .finished(root_fin)
  );

  qte_cordic u_yaw (
    .clk(clk), .rst(rst), .start(angle_start),
    .vec_x(yaw_x), .vec_y(yaw_y), .angle(yaw_raw), .finished(yaw_fin)
  );

  qte_cordic u_roll (
    .clk(clk), .rst(rst), .start(angle_start),
    .vec_x(roll_x), .vec_y(roll_y), .angle(roll_raw), .finished(roll_fin)
  );

  qte_cordic u_pitch (
    .clk(clk), .rst(rst), .start(pitch_start),
    .vec_x(pitch_x), .vec_y(pitch_y), .angle(pitch_raw), .finished(pitch_fin)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      roll_trim  <= 18'sd421;
      pitch_trim <= -18'sd1769;
      roll_acc   <= '0;
      pitch_acc  <= '0;
      sample_cnt <= '0;
      active     <= 1'b0;
      div_cnt    <= '0;
    end else begin
      if (out_valid && out_ready && state != S_OUT) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            // a request restarts averaging with this sample
            if (start_calibration) begin
              roll_trim  <= '0;
              pitch_trim <= '0;
              roll_acc   <= '0;
              pitch_acc  <= '0;
              sample_cnt <= '0;
              active     <= 1'b1;
            end
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (mul_fin) state <= S_ROOT;
        end
        S_ROOT: begin
          if (root_fin) state <= S_ANGLE;
        end
        S_ANGLE: begin
          if (yaw_fin && roll_fin && pitch_fin) state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid        <= 1'b1;
            yaw_angle        <= 17'(sat20(20'(yaw_raw), LIM_HALF));
            pitch_angle      <= 17'(sat20(20'(pitch_raw) - 20'(pitch_trim), LIM_HALF));
            roll_angle       <= 18'(sat20(20'(roll_raw) - 20'(roll_trim), LIM_FULL));
            calibrating      <= active && !final_hit;
            calibration_done <= final_hit;
            state            <= final_hit ? S_DIV : S_IDLE;
            if (active) begin
              roll_acc   <= roll_sum;
              pitch_acc  <= pitch_sum;
              sample_cnt <= final_hit ? 7'd0 : cnt_inc;
            end
            // last sample: divide the sums into new trims
            if (final_hit) begin
              active    <= 1'b0;
              roll_q    <= mag_half(roll_sum);
              pitch_q   <= mag_half(pitch_sum);
              roll_neg  <= roll_sum[TACC_W-1];
              pitch_neg <= pitch_sum[TACC_W-1];
              roll_rem  <= '0;
              pitch_rem <= '0;
              div_cnt   <= '0;
            end
          end
        end
        S_DIV: begin
          roll_rem  <= roll_qb ? REM_W'(roll_r2 - (REM_W + 1)'(TRIM_SAMPLES))
                               : REM_W'(roll_r2);
          pitch_rem <= pitch_qb ? REM_W'(pitch_r2 - (REM_W + 1)'(TRIM_SAMPLES))
                                : REM_W'(pitch_r2);
          roll_q    <= {roll_q[TACC_W-2:0], roll_qb};
          pitch_q   <= {pitch_q[TACC_W-2:0], pitch_qb};
          div_cnt   <= div_cnt + 1'b1;
          if (div_cnt == TACC_CNT_W'(TACC_W - 1)) begin
            roll_trim  <= roll_neg ? -18'({roll_q[TACC_W-2:0], roll_qb})
                                   : 18'({roll_q[TACC_W-2:0], roll_qb});
            pitch_trim <= pitch_neg ? -18'({pitch_q[TACC_W-2:0], pitch_qb})
                                    : 18'({pitch_q[TACC_W-2:0], pitch_qb});
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/qte_mul.sv */
// ----------------------------------------------------------------------------
// qte_mul: bit-serial sums of quaternion products
// Forms the five product sums of the rotation matrix terms, taking one
// multiplier bit per cycle, MSB first, with the MSB weighted negative.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qte_mul
  import qte_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  output prod_t              prod,
  output logic               finished
);

  localparam int CNT_W = $clog2(MUL_BITS);

  logic [15:0]        sh_x, sh_y, sh_z;
  logic signed [16:0] m_w, m_x, m_y, m_z, m_nx;
  logic [CNT_W-1:0]   cnt;
  logic               run;
  logic               first;
  prod_t              prod_next;

  // one partial product: the first bit carries negative weight
  function automatic logic signed [ACC_W-1:0] pp(input logic b, input logic f,
                                                 input logic signed [16:0] m);
    logic signed [ACC_W-1:0] r;
    if (!b) r = '0;
    else if (f) r = -ACC_W'(m);
    else r = ACC_W'(m);
    return r;
  endfunction

  assign first = (cnt == '0);

  // shift-accumulate all five sums
  always_comb begin
    prod_next.yaw_num   = (prod.yaw_num <<< 1) + pp(sh_y[15], first, m_x)
                          + pp(sh_z[15], first, m_w);
    prod_next.yaw_den   = (prod.yaw_den <<< 1) + pp(sh_y[15], first, m_y)
                          + pp(sh_z[15], first, m_z);
    prod_next.roll_num  = (prod.roll_num <<< 1) + pp(sh_z[15], first, m_y)
                          + pp(sh_x[15], first, m_w);
    prod_next.roll_den  = (prod.roll_den <<< 1) + pp(sh_x[15], first, m_x)
                          + pp(sh_y[15], first, m_y);
    prod_next.pitch_sin = (prod.pitch_sin <<< 1) + pp(sh_y[15], first, m_w)
                          + pp(sh_z[15], first, m_nx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run      <= 1'b0;
      finished <= 1'b0;
      cnt      <= '0;
    end else if (start) begin
      run      <= 1'b1;
      finished <= 1'b0;
      cnt      <= '0;
      sh_x     <= quat_x;
      sh_y     <= quat_y;
      sh_z     <= quat_z;
      m_w      <= 17'(quat_w);
      m_x      <= 17'(quat_x);
      m_y      <= 17'(quat_y);
      m_z      <= 17'(quat_z);
      m_nx     <= -17'(quat_x);
      prod     <= '0;
    end else if (run) begin
      prod <= prod_next;
      sh_x <= {sh_x[14:0], 1'b0};
      sh_y <= {sh_y[14:0], 1'b0};
      sh_z <= {sh_z[14:0], 1'b0};
      cnt  <= cnt + 1'b1;
      if (cnt == CNT_W'(MUL_BITS - 1)) begin
        run      <= 1'b0;
        finished <= 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/qte_root.sv */
// ----------------------------------------------------------------------------
// qte_root: cosine term for the pitch arcsine
// Squares the clamped sine one bit per cycle, then takes the floor square
// root of (1 - s*s) in Q60, one result bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qte_root
  import qte_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [S_W-1:0] sine,
  output logic [SQ_W-1:0]      cosine,
  output logic                 finished
);

  localparam int RAD_W = 2 * SQ_W;
  localparam int REM_R = SQ_W + 3;
  localparam int CNT_W = $clog2(SQ_W);

  typedef enum logic [1:0] {R_IDLE, R_SQUARE, R_ROOT} phase_t;

  phase_t             phase;
  logic [SQ_W-1:0]    mag, mult;
  logic [RAD_W-1:0]   sq, sq_next, rad;
  logic [REM_R-1:0]   rem, r2, trial;
  logic [CNT_W-1:0]   cnt;
  logic signed [S_W-1:0] sabs;

  assign sabs    = sine[S_W-1] ? -sine : sine;
  assign sq_next = {sq[RAD_W-2:0], 1'b0} + (mag[SQ_W-1] ? RAD_W'(mult) : '0);
  assign r2      = {rem[REM_R-3:0], rad[RAD_W-1:RAD_W-2]};
  assign trial   = {1'b0, cosine, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= R_IDLE;
      finished <= 1'b0;
      cnt      <= '0;
    end else begin
      unique case (phase)
        R_IDLE: begin
          if (start) begin
            mult     <= sabs[SQ_W-1:0];
            mag      <= sabs[SQ_W-1:0];
            sq       <= '0;
            cnt      <= '0;
            finished <= 1'b0;
            phase    <= R_SQUARE;
          end
        end
        R_SQUARE: begin
          // shift in one multiplier bit of s*s
          sq  <= sq_next;
          mag <= {mag[SQ_W-2:0], 1'b0};
          if (cnt == CNT_W'(SQ_W - 1)) begin
            rad    <= (RAD_W'(1) << (RAD_W - 2)) - sq_next;
            rem    <= '0;
            cosine <= '0;
            cnt    <= '0;
            phase  <= R_ROOT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        R_ROOT: begin
          // one root bit from the next two radicand bits
          if (r2 >= trial) begin
            rem    <= r2 - trial;
            cosine <= {cosine[SQ_W-2:0], 1'b1};
          end else begin
            rem    <= r2;
            cosine <= {cosine[SQ_W-2:0], 1'b0};
          end
          rad <= {rad[RAD_W-3:0], 2'b00};
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(SQ_W - 1)) begin
            finished <= 1'b1;
            phase    <= R_IDLE;
          end
        end
        default: phase <= R_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/qte_cordic.sv */
// ----------------------------------------------------------------------------
// qte_cordic: iterative vectoring CORDIC for atan2
// One micro-rotation per cycle; stops early once y reaches zero. The angle
// is kept in Q16 degrees and rounded to 1/256 degree at the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qte_cordic
  import qte_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic signed [CW-1:0]   vec_x,
  input  logic signed [CW-1:0]   vec_y,
  output logic signed [ANG_W-1:0] angle,
  output logic                   finished
);

  localparam logic signed [ZW-1:0] DEG180 = ZW'(180 * 65536);

  logic signed [CW-1:0] cx, cy, sx, sy;
  logic signed [ZW-1:0] cz, tab, rnd;
  logic [STEP_W-1:0]    step;
  logic                 run;

  assign sx    = cx >>> step;
  assign sy    = cy >>> step;
  assign tab   = ZW'(atan_deg(5'(step)));
  assign rnd   = cz + ZW'(128);
  assign angle = rnd[ZW-1:8];

  always_ff @(posedge clk) begin
    if (rst) begin
      run      <= 1'b0;
      finished <= 1'b0;
      step     <= '0;
    end else if (start) begin
      run      <= 1'b1;
      finished <= 1'b0;
      step     <= '0;
      // fold the left half plane onto the right
      if (vec_x < 0) begin
        cz <= (vec_y >= 0) ? DEG180 : -DEG180;
        cx <= -vec_x;
        cy <= -vec_y;
      end else begin
        cz <= '0;
        cx <= vec_x;
        cy <= vec_y;
      end
    end else if (run) begin
      if (step == STEP_W'(CORDIC_ITERS) || cy == '0) begin
        run      <= 1'b0;
        finished <= 1'b1;
      end else begin
        // rotate toward the x axis
        if (cy > 0) begin
          cx <= cx + sy;
          cy <= cy - sx;
          cz <= cz + tab;
        end else begin
          cx <= cx - sy;
          cy <= cy + sx;
          cz <= cz - tab;
        end
        step <= step + 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/qte_check.sv */
// ----------------------------------------------------------------------------
// qte_check: port-level checks for the quaternion to Euler block
// Watches the handshakes and result ranges, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qte_check
  import qte_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic signed [15:0] quat_w,
  input logic signed [15:0] quat_x,
  input logic signed [15:0] quat_y,
  input logic signed [15:0] quat_z,
  input logic               start_calibration,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [16:0] yaw_angle,
  input logic signed [16:0] pitch_angle,
  input logic signed [17:0] roll_angle,
  input logic               calibrating,
  input logic               calibration_done
);

  // hold a waiting input item
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(quat_w) && $stable(quat_x) &&
                              $stable(quat_y) && $stable(quat_z) &&
                              $stable(start_calibration))
    else $error("waiting input item changed");

  // hold a stalled result: valid, yaw and roll stay
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(yaw_angle) && $stable(roll_angle))
    else $error("stalled result changed");

  // one item at a time: ready drops after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while busy");

  // the sample that loads trims ends averaging
  a_done_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && calibration_done |-> !calibrating)
    else $error("calibration_done with calibrating");

  // results stay in range
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> yaw_angle >= -46080 && yaw_angle <= 46080 &&
                  pitch_angle >= -46080 && pitch_angle <= 46080 &&
                  roll_angle >= -92160 && roll_angle <= 92160)
    else $error("angle out of range");

endmodule

bind quaternion_to_euler_with_level_trim qte_check u_check (.*);

/* sim/tb_quaternion_to_euler_with_level_trim.sv */
// ----------------------------------------------------------------------------
// tb_quaternion_to_euler_with_level_trim: self-checking testbench
// Drives attitude quaternions with random gaps and output stalls, predicts
// yaw, pitch and roll with trim and calibration state, and compares each
// result item field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_quaternion_to_euler_with_level_trim;
  import qte_pkg::*;

  localparam longint CYCLE_LIMIT = 3000000;
  localparam longint Q30_ONE     = longint'(1) << 30;
  localparam longint HALF_TURN   = longint'(180) * 65536;

  typedef struct {
    logic signed [16:0] yaw;
    logic signed [16:0] pitch;
    logic signed [17:0] roll;
    logic               busy;
    logic               done;
  } angles_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] quat_w = '0;
  logic signed [15:0] quat_x = '0;
  logic signed [15:0] quat_y = '0;
  logic signed [15:0] quat_z = '0;
  logic               start_calibration = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [16:0] yaw_angle;
  logic signed [16:0] pitch_angle;
  logic signed [17:0] roll_angle;
  logic               calibrating;
  logic               calibration_done;

  // predictor state
  longint trim_roll, trim_pitch, sum_roll, sum_pitch;
  int     trim_count;
  bit     trim_active;
  angles_t pending_angles[$];

  longint cycles = 0;
  int     errors = 0;
  int     items_sent = 0;
  int     items_checked = 0;
  int     trims_loaded = 0;
  bit     idle_in = 1'b1;
  bit     idle_out = 1'b1;
  int     stall_left = 0;

  longint atan_q16[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
    58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7,
    4, 2, 1, 0};

  quaternion_to_euler_with_level_trim u_top (.*);

  always #5 clk = ~clk;

  // abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver stalls: mostly short, some long, none while idle_out is clear
  always @(posedge clk) begin
    if (!idle_out) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 150)
                                                 : $urandom_range(0, 4);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic longint cordic_angle(longint yv, longint xv);
    longint zacc, nx, ny;
    zacc = 0;
    if (xv == 0 && yv == 0) return 0;
    if (xv < 0) begin
      zacc = (yv >= 0) ? HALF_TURN : -HALF_TURN;
      xv = -xv;
      yv = -yv;
    end
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      if (yv == 0) break;
      if (yv > 0) begin
        nx = xv + (yv >>> i); ny = yv - (xv >>> i); zacc += atan_q16[i];
      end else begin
        nx = xv - (yv >>> i); ny = yv + (xv >>> i); zacc -= atan_q16[i];
      end
      xv = nx; yv = ny;
    end
    return (zacc + 128) >>> 8;
  endfunction

  function automatic longint root_floor(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = longint'(1) << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b; r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint trim_average(longint total);
    if (total >= 0) return (total + TRIM_SAMPLES / 2) / TRIM_SAMPLES;
    return -((-total + TRIM_SAMPLES / 2) / TRIM_SAMPLES);
  endfunction

  function automatic longint clip(longint v, longint lim);
    return (v < -lim) ? -lim : ((v > lim) ? lim : v);
  endfunction

  // advance the trim state for one accepted item and return its angles
  function automatic angles_t predict_angles(longint w, longint x, longint y,
                                             longint z, bit cal);
    angles_t a;
    longint yaw, roll, pitch, s;
    if (cal) begin
      trim_roll = 0; trim_pitch = 0; sum_roll = 0; sum_pitch = 0;
      trim_count = 0; trim_active = 1'b1;
    end
    yaw   = cordic_angle(2 * (x * y + w * z), Q30_ONE - 2 * (y * y + z * z));
    roll  = cordic_angle(2 * (y * z + w * x), Q30_ONE - 2 * (x * x + y * y));
    s     = 2 * (w * y - x * z);
    s     = (s < -Q30_ONE) ? -Q30_ONE : ((s > Q30_ONE) ? Q30_ONE : s);
    pitch = cordic_angle(s, root_floor((longint'(1) << 60) - s * s));
    a.yaw   = 17'(clip(yaw, 46080));
    a.pitch = 17'(clip(pitch - trim_pitch, 46080));
    a.roll  = 18'(clip(roll - trim_roll, 92160));
    a.done  = 1'b0;
    if (trim_active) begin
      sum_roll += roll; sum_pitch += pitch;
      trim_count++;
      if (trim_count >= TRIM_SAMPLES) begin
        trim_roll = trim_average(sum_roll);
        trim_pitch = trim_average(sum_pitch);
        trim_count = 0; trim_active = 1'b0; a.done = 1'b1;
        trims_loaded++;
      end
    end
    a.busy = trim_active;
    return a;
  endfunction

  // offer one item, hold it until accepted, then, while idle_in is set, sometimes idle for a random gap
  task automatic send_item(logic signed [15:0] w, logic signed [15:0] x,
                           logic signed [15:0] y, logic signed [15:0] z, bit cal);
    int gap;
    quat_w <= w; quat_x <= x; quat_y <= y; quat_z <= z;
    start_calibration <= cal;
    in_valid <= 1'b1;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    pending_angles.push_back(predict_angles(w, x, y, z, cal));
    items_sent++;
    gap = 0;
    if (idle_in && $urandom_range(0, 2) == 0)
      gap = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 200)
                                          : $urandom_range(1, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // unit attitude with random orientation, tilt limited by tilt_scale
  task automatic send_attitude(real tilt_scale, bit cal);
    real w, x, y, z, n;
    w = 1.0 + $urandom_range(0, 65535) / 65536.0;
    x = tilt_scale * ($urandom_range(0, 65535) / 32768.0 - 1.0);
    y = tilt_scale * ($urandom_range(0, 65535) / 32768.0 - 1.0);
    z = $urandom_range(0, 65535) / 32768.0 - 1.0;
    if ($urandom_range(0, 1)) w = -w;
    n = $sqrt(w * w + x * x + y * y + z * z);
    send_item(16'($rtoi(w / n * 32767.0)), 16'($rtoi(x / n * 32767.0)),
              16'($rtoi(y / n * 32767.0)), 16'($rtoi(z / n * 32767.0)), cal);
  endtask

  task automatic send_noise(bit cal);
    send_item(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), cal);
  endtask

  // check each result item against the oldest prediction
  always @(negedge clk) begin
    angles_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_angles.size() == 0) begin
        $display("%0t: result item with nothing expected", $time);
        errors++;
      end else begin
        e = pending_angles.pop_front();
        items_checked++;
        if (yaw_angle !== e.yaw) begin
          $display("%0t: yaw exp %0d got %0d", $time, e.yaw, yaw_angle);
          errors++;
        end
        if (pitch_angle !== e.pitch) begin
          $display("%0t: pitch exp %0d got %0d", $time, e.pitch, pitch_angle);
          errors++;
        end
        if (roll_angle !== e.roll) begin
          $display("%0t: roll exp %0d got %0d", $time, e.roll, roll_angle);
          errors++;
        end
        if (calibrating !== e.busy) begin
          $display("%0t: calibrating exp %0b got %0b", $time, e.busy, calibrating);
          errors++;
        end
        if (calibration_done !== e.done) begin
          $display("%0t: calibration_done exp %0b got %0b", $time, e.done,
                   calibration_done);
          errors++;
        end
      end
    end
  end

  // extremes and corner geometries, starting from reset trims
  task automatic test_directed();
    send_item(16'sh7fff, 0, 0, 0, 1'b0);
    send_item(-16'sh8000, 0, 0, 0, 1'b0);
    send_item(0, 0, 0, 0, 1'b0);
    send_item(0, 0, 16384, 16384, 1'b0);          // yaw from the zero vector
    send_item(0, 0, 0, -16'sh8000, 1'b0);         // yaw on the negative real axis
    send_item(0, -16'sh8000, 0, 0, 1'b0);         // roll on the negative real axis
    send_item(0, 16'sh7fff, 0, 0, 1'b0);
    send_item(16'sh7fff, 0, 16'sh7fff, 0, 1'b0);  // asin argument past +1
    send_item(16'sh7fff, 0, -16'sh8000, 0, 1'b0); // asin argument past -1
    send_item(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0);
    send_item(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, 1'b0);
    send_item(23170, 0, 23170, 0, 1'b0);
    send_item(23170, 0, -23170, 0, 1'b0);
    send_item(23170, 23170, 0, 0, 1'b0);
    send_item(23170, -23170, 0, 0, 1'b0);
    send_item(16'sh5555, -16'sh2aab, 16'sh0001, -16'sh0001, 1'b0);
    send_item(1, -1, 1, -1, 1'b0);
  endtask

  // full averaging passes, level and tilted
  task automatic test_calibration(real tilt_scale);
    send_attitude(tilt_scale, 1'b1);
    for (int i = 1; i < TRIM_SAMPLES; i++) send_attitude(tilt_scale, 1'b0);
  endtask

  // request again partway through averaging
  task automatic test_restart();
    send_attitude(0.1, 1'b1);
    repeat (40) send_attitude(0.1, 1'b0);
    send_attitude(0.1, 1'b1);
    for (int i = 1; i < TRIM_SAMPLES; i++) send_attitude(0.1, 1'b0);
  endtask

  // random attitudes mixed with raw noise and stray calibration requests
  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 4) == 0) send_noise($urandom_range(0, 40) == 0);
      else send_attitude(1.0, 1'b0);
    end
  endtask

  initial begin
    trim_roll = 421; trim_pitch = -1769; sum_roll = 0; sum_pitch = 0;
    trim_count = 0; trim_active = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(300);
    idle_in = 1'b0; idle_out = 1'b0;
    test_calibration(0.15);
    idle_in = 1'b1; idle_out = 1'b1;
    test_random(150);
    test_calibration(1.0);
    test_restart();
    test_random(200);
    test_calibration(0.05);
    test_random(150);
    in_valid <= 1'b0;

    while (pending_angles.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("sent %0d quaternions, checked %0d angle sets", items_sent,
             items_checked);
    $display("trim loads completed: %0d, one restarted mid-average", trims_loaded);
    if (errors == 0 && pending_angles.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
